// ===== hw/rtl/hrlp_pkg.sv =====
// Shared types, widths and codes for the HTTP request line parser.
package hrlp_pkg;

  // Longest request that is parsed; longer ones are flagged
  localparam int MAX_LEN = 4096;
  // Byte counter width: holds 0..MAX_LEN
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  // Offset width inside a request: 0..MAX_LEN-1
  localparam int OFS_W   = $clog2(MAX_LEN);

  // Fixed field widths of the result word
  localparam int STATUS_W = 3;
  localparam int METHOD_W = 2;
  localparam int POFF_W   = 12;
  localparam int PLEN_W   = 13;
  localparam int BOFF_W   = 12;
  localparam int LIMIT_W  = 13;

  // Method codes
  localparam logic [METHOD_W-1:0] M_NONE    = 2'd0;
  localparam logic [METHOD_W-1:0] M_GET     = 2'd1;
  localparam logic [METHOD_W-1:0] M_POST    = 2'd2;
  localparam logic [METHOD_W-1:0] M_OPTIONS = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_METHOD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BODY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PATH   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PATH_LONG = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REQ_LONG  = 3'd5;

  // Characters
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Lowercase method words, oldest byte in the high bits
  localparam logic [23:0] WORD_GET     = "get";
  localparam logic [31:0] WORD_POST    = "post";
  localparam logic [55:0] WORD_OPTIONS = "options";
  localparam logic [31:0] WORD_CRLF2   = {CH_CR, CH_LF, CH_CR, CH_LF};

  // Lengths the request must exceed past the method start
  localparam logic [3:0] NEED_GET     = 4'd3;
  localparam logic [3:0] NEED_POST    = 4'd4;
  localparam logic [3:0] NEED_OPTIONS = 4'd7;

  // Reset value of the path length limit
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd256;

  // One accepted input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } word_t;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [METHOD_W-1:0] method;
    logic [POFF_W-1:0]   path_offset;
    logic [PLEN_W-1:0]   path_length;
    logic [BOFF_W-1:0]   body_offset;
  } result_t;

  // ASCII lowercase of seven bytes at once
  function automatic logic [55:0] lower7(input logic [55:0] w);
    logic [55:0] r;
    logic [7:0]  c;
    for (int i = 0; i < 7; i++) begin
      c = w[8*i +: 8];
      if (c >= 8'h41 && c <= 8'h5A) begin
        r[8*i +: 8] = c + 8'd32;
      end else begin
        r[8*i +: 8] = c;
      end
    end
    return r;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_CR) || (c == CH_LF) || (c == CH_QMARK);
  endfunction

endpackage

// ===== hw/rtl/http_request_line_parser_top.sv =====
// HTTP request line parser, one request byte per cycle, one result word per request.
//
// Takes one request byte per cycle with a last flag and gives one result word
// after the last byte: status, method (GET, POST or OPTIONS, case-insensitive,
// after leading spaces), path offset and length, and POST body offset. Each
// byte passes an input register and one scan stage that updates the request
// state and, on the last byte, writes the result register, which holds the result
// word; bytes are taken every cycle while the result register drains. Only a
// finished result held back by out_ready stalls the input. Requests over 4096
// bytes report request too long. The path length limit (cfg_wdata, reset 256)
// is written with cfg_we; write it only while idle, the block does not enforce it.
module http_request_line_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_is_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hrlp_pkg::STATUS_W-1:0]   out_status,
  output logic [hrlp_pkg::METHOD_W-1:0]   out_method,
  output logic [hrlp_pkg::POFF_W-1:0]     out_path_offset,
  output logic [hrlp_pkg::PLEN_W-1:0]     out_path_length,
  output logic [hrlp_pkg::BOFF_W-1:0]     out_body_offset,
  input  logic                            cfg_we,
  input  logic [hrlp_pkg::LIMIT_W-1:0]    cfg_wdata
);
  import hrlp_pkg::*;

  word_t               in_word;
  word_t               s_word;
  logic                s_vld;
  logic                go;
  logic                space;
  result_t             res;
  result_t             out_res;
  logic [LIMIT_W-1:0]  limit_r;

  assign in_word.data_byte = in_data_byte;
  assign in_word.is_last   = in_is_last;

  // Path length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Scan stage advances unless a last byte finds no space in the result register
  assign go = s_vld && (!s_word.is_last || space);

  hrlp_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .take     (go),
    .vld      (s_vld),
    .word     (s_word)
  );

  hrlp_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .word         (s_word),
    .max_path_len (limit_r),
    .res          (res)
  );

  hrlp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && s_word.is_last),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status      = out_res.status;
  assign out_method      = out_res.method;
  assign out_path_offset = out_res.path_offset;
  assign out_path_length = out_res.path_length;
  assign out_body_offset = out_res.body_offset;

endmodule

// ===== hw/rtl/hrlp_in_reg.sv =====
// Input register: holds one accepted byte word for the scan stage.
module hrlp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hrlp_pkg::word_t in_word,
  input  logic           take,
  output logic           vld,
  output hrlp_pkg::word_t word
);
  import hrlp_pkg::*;

  logic  vld_r;
  word_t word_r;

  // Free when empty or when the held word moves on this cycle
  assign in_ready = !vld_r || take;
  assign vld      = vld_r;
  assign word     = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

// ===== hw/rtl/hrlp_scan.sv =====
// Request scan: per-request tracking state and the result on the last byte.
module hrlp_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  hrlp_pkg::word_t           word,
  input  logic [hrlp_pkg::LIMIT_W-1:0] max_path_len,
  output hrlp_pkg::result_t         res
);
  import hrlp_pkg::*;

  // State registers
  logic [POS_W-1:0]    pos_r,       pos_nxt;
  logic                skip_r,      skip_nxt;
  logic [OFS_W-1:0]    mstart_r,    mstart_nxt;
  logic [47:0]         recent_r,    recent_nxt;
  logic [METHOD_W-1:0] meth_r,      meth_nxt;
  logic [POS_W-1:0]    uri_r,       uri_nxt;
  logic                sseen_r,     sseen_nxt;
  logic [OFS_W-1:0]    spos_r,      spos_nxt;
  logic                closed_r,    closed_nxt;
  logic [OFS_W-1:0]    pend_r,      pend_nxt;
  logic                bseen_r,     bseen_nxt;
  logic [POS_W-1:0]    bpos_r,      bpos_nxt;

  logic [7:0]       b;
  logic             proc;
  logic [55:0]      lw;
  logic [OFS_W-1:0] d;
  logic [POS_W:0]   uri_p3;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] kp1;
  logic [3:0]       need;
  logic [POS_W-1:0] mend;
  logic [POS_W-1:0] pstop;
  logic [POS_W-1:0] plen;

  assign b    = word.data_byte;
  assign proc = pos_r < POS_W'(MAX_LEN);
  assign kp1  = pos_r + 1'b1;

  // Per-byte state update
  always_comb begin
    pos_nxt    = pos_r;
    skip_nxt   = skip_r;
    mstart_nxt = mstart_r;
    recent_nxt = recent_r;
    meth_nxt   = meth_r;
    uri_nxt    = uri_r;
    sseen_nxt  = sseen_r;
    spos_nxt   = spos_r;
    closed_nxt = closed_r;
    pend_nxt   = pend_r;
    bseen_nxt  = bseen_r;
    bpos_nxt   = bpos_r;
    lw         = lower7({recent_r, b});
    d          = '0;
    uri_p3     = {1'b0, uri_r} + (POS_W+1)'(3);
    if (proc) begin
      recent_nxt = {recent_r[39:0], b};
      // first non-space byte opens the method word
      if (skip_r && b != CH_SP) begin
        skip_nxt   = 1'b0;
        mstart_nxt = pos_r[OFS_W-1:0];
      end
      d = pos_r[OFS_W-1:0] - mstart_nxt;
      if (!skip_nxt && meth_r == M_NONE) begin
        // method word match on the byte that ends it
        if (d == OFS_W'(2) && lw[23:0] == WORD_GET) begin
          meth_nxt = M_GET;
          uri_nxt  = kp1;
        end else if (d == OFS_W'(3) && lw[31:0] == WORD_POST) begin
          meth_nxt = M_POST;
          uri_nxt  = kp1;
        end else if (d == OFS_W'(6) && lw == WORD_OPTIONS) begin
          meth_nxt = M_OPTIONS;
          uri_nxt  = kp1;
        end
      end else if (meth_r != M_NONE) begin
        // path start and end
        if (!sseen_r) begin
          if (b == CH_SLASH && !word.is_last) begin
            sseen_nxt = 1'b1;
            spos_nxt  = pos_r[OFS_W-1:0];
          end
        end else if (!closed_r && is_term(b)) begin
          closed_nxt = 1'b1;
          pend_nxt   = pos_r[OFS_W-1:0];
        end
        // POST body after the first blank line
        if (meth_r == M_POST && !bseen_r && {1'b0, pos_r} >= uri_p3 &&
            recent_nxt[31:0] == WORD_CRLF2) begin
          bseen_nxt = 1'b1;
          bpos_nxt  = kp1;
        end
      end
      pos_nxt = kp1;
    end
  end

  // Result from the updated state
  always_comb begin
    len = kp1;
    case (meth_nxt)
      M_GET:   need = NEED_GET;
      M_POST:  need = NEED_POST;
      default: need = NEED_OPTIONS;
    endcase
    mend  = POS_W'(mstart_nxt) + POS_W'(need);
    pstop = closed_nxt ? POS_W'(pend_nxt) : len;
    plen  = pstop - POS_W'(spos_nxt);
    res   = '0;
    if (!proc) begin
      res.status = ST_REQ_LONG;
    end else if (meth_nxt == M_NONE || mend >= len) begin
      res.status = ST_NO_METHOD;
    end else if (meth_nxt == M_POST && (!bseen_nxt || bpos_nxt >= len)) begin
      res.status = ST_NO_BODY;
      res.method = M_POST;
    end else begin
      res.method = meth_nxt;
      if (meth_nxt == M_POST) begin
        res.body_offset = BOFF_W'(bpos_nxt);
      end
      if (!sseen_nxt) begin
        res.status = ST_NO_PATH;
      end else begin
        res.path_offset = POFF_W'(spos_nxt);
        res.path_length = PLEN_W'(plen);
        res.status = (32'(plen) < 32'(max_path_len)) ? ST_OK : ST_PATH_LONG;
      end
    end
  end

  // State registers; cleared after the last byte of each request
  always_ff @(posedge clk) begin
    if (!rst_n || (go && word.is_last)) begin
      pos_r    <= '0;
      skip_r   <= 1'b1;
      mstart_r <= '0;
      recent_r <= '0;
      meth_r   <= M_NONE;
      uri_r    <= '0;
      sseen_r  <= 1'b0;
      spos_r   <= '0;
      closed_r <= 1'b0;
      pend_r   <= '0;
      bseen_r  <= 1'b0;
      bpos_r   <= '0;
    end else if (go) begin
      pos_r    <= pos_nxt;
      skip_r   <= skip_nxt;
      mstart_r <= mstart_nxt;
      recent_r <= recent_nxt;
      meth_r   <= meth_nxt;
      uri_r    <= uri_nxt;
      sseen_r  <= sseen_nxt;
      spos_r   <= spos_nxt;
      closed_r <= closed_nxt;
      pend_r   <= pend_nxt;
      bseen_r  <= bseen_nxt;
      bpos_r   <= bpos_nxt;
    end
  end

endmodule

// ===== hw/rtl/hrlp_out_reg.sv =====
// Output register: holds one result word until the consumer takes it.
module hrlp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hrlp_pkg::result_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output hrlp_pkg::result_t out_res
);
  import hrlp_pkg::*;

  logic    vld_r;
  result_t res_r;

  // A new word may land when empty or when the held one leaves now
  assign space     = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (space) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_r <= res;
    end
  end

endmodule

// ===== dv/tb_http_request_line_parser_top.sv =====
// Self-checking testbench for the HTTP request line parser: directed and random requests.
module tb_http_request_line_parser_top;
  import hrlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50000;

  // Byte-serial model of the parser plus the queue of results it owes
  class request_line_tracker;
    logic [LIMIT_W-1:0]  path_limit;
    int unsigned         pos, word_start, uri_from, slash_at, path_stop, body_at;
    bit                  in_lead, have_slash, path_done, have_body;
    logic [63:0]         last8;
    logic [METHOD_W-1:0] verb;
    result_t             due_results[$];
    int                  errors;

    function new();
      path_limit = LIMIT_RST;
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos = 0;
      in_lead = 1'b1;
      word_start = 0;
      last8 = '0;
      verb = M_NONE;
      uri_from = 0;
      have_slash = 1'b0;
      slash_at = 0;
      path_done = 1'b0;
      path_stop = 0;
      have_body = 1'b0;
      body_at = 0;
    endfunction

    // Newest n bytes, case-folded, against a lowercase word (oldest byte high)
    function bit tail_matches(logic [55:0] word, int n);
      logic [7:0] c;
      for (int t = 0; t < n; t++) begin
        c = last8[8*(n-1-t) +: 8];
        if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
        if (c != word[8*(n-1-t) +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // One accepted word; on the last byte the expected result is queued
    function void take_byte(logic [7:0] b, bit last);
      int unsigned k, span, need, req_len, plen;
      result_t     r;
      k = pos;
      if (k < MAX_LEN) begin
        last8 = {last8[55:0], b};
        if (in_lead && b != CH_SP) begin
          in_lead = 1'b0;
          word_start = k;
        end
        if (!in_lead && verb == M_NONE) begin
          span = k - word_start;
          if (span == 2 && tail_matches(56'(WORD_GET), 3)) begin
            verb = M_GET;
            uri_from = k + 1;
          end else if (span == 3 && tail_matches(56'(WORD_POST), 4)) begin
            verb = M_POST;
            uri_from = k + 1;
          end else if (span == 6 && tail_matches(WORD_OPTIONS, 7)) begin
            verb = M_OPTIONS;
            uri_from = k + 1;
          end
        end else if (verb != M_NONE && k >= uri_from) begin
          if (!have_slash) begin
            // a slash on the final byte never opens a path
            if (b == CH_SLASH && !last) begin
              have_slash = 1'b1;
              slash_at = k;
            end
          end else if (!path_done &&
                       (b == CH_SP || b == CH_CR || b == CH_LF || b == CH_QMARK)) begin
            path_done = 1'b1;
            path_stop = k;
          end
          if (verb == M_POST && !have_body && k >= uri_from + 3 &&
              last8[31:0] == WORD_CRLF2) begin
            have_body = 1'b1;
            body_at = k + 1;
          end
        end
        pos = k + 1;
      end
      if (!last) return;

      r = '0;
      req_len = k + 1;
      if (k >= MAX_LEN) begin
        r.status = ST_REQ_LONG;
      end else begin
        need = (verb == M_GET) ? 32'(NEED_GET) :
               (verb == M_POST) ? 32'(NEED_POST) : 32'(NEED_OPTIONS);
        if (verb == M_NONE || word_start + need >= req_len) begin
          r.status = ST_NO_METHOD;
        end else if (verb == M_POST && (!have_body || body_at >= req_len)) begin
          r.status = ST_NO_BODY;
          r.method = M_POST;
        end else begin
          r.method = verb;
          if (verb == M_POST) r.body_offset = BOFF_W'(body_at);
          if (!have_slash) begin
            r.status = ST_NO_PATH;
          end else begin
            plen = (path_done ? path_stop : req_len) - slash_at;
            r.path_offset = POFF_W'(slash_at);
            r.path_length = PLEN_W'(plen);
            r.status = (plen < path_limit) ? ST_OK : ST_PATH_LONG;
          end
        end
      end
      due_results.push_back(r);
      clear();
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // One accepted result word against the oldest one owed
    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t result with none due: status %0d method %0d path %0d+%0d body %0d",
                 $time, got.status, got.method, got.path_offset, got.path_length,
                 got.body_offset);
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("method", want.method, got.method);
      compare_field("path_offset", want.path_offset, got.path_offset);
      compare_field("path_length", want.path_length, got.path_length);
      compare_field("body_offset", want.body_offset, got.body_offset);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_data_byte = '0;
  logic                in_is_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [METHOD_W-1:0] out_method;
  logic [POFF_W-1:0]   out_path_offset;
  logic [PLEN_W-1:0]   out_path_length;
  logic [BOFF_W-1:0]   out_body_offset;
  logic                cfg_we = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata = '0;

  request_line_tracker tracker;
  logic [7:0]          req_bytes[$];
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int unsigned         cycle_count = 0;

  http_request_line_parser_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_method      (out_method),
    .out_path_offset (out_path_offset),
    .out_path_length (out_path_length),
    .out_body_offset (out_body_offset),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Handshakes are sampled mid-cycle, where every signal has settled
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_byte(in_data_byte, in_is_last);
      if (out_valid && out_ready) begin
        tracker.match_result(result_t'({out_status, out_method, out_path_offset,
                                        out_path_length, out_body_offset}));
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Request builders
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) req_bytes.push_back(CH_SP);
  endfunction

  // Path characters only: no space, CR, LF or question mark
  function automatic void add_fill(int n);
    string alphabet;
    alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJ0123456789-._~/%=&";
    repeat (n) req_bytes.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) req_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Method word with each letter in random case
  function automatic void add_verb(logic [METHOD_W-1:0] v);
    string      w;
    logic [7:0] c;
    if (v == M_GET) w = "get";
    else if (v == M_POST) w = "post";
    else w = "options";
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if ($urandom_range(1) != 0) c = c - 8'd32;
      req_bytes.push_back(c);
    end
  endfunction

  // Sender side
  task automatic send_word(logic [7:0] b, bit last);
    bit took;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_is_last <= last;
    do begin
      @(negedge clk);
      took = in_valid && in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_request();
    for (int i = 0; i < req_bytes.size(); i++) send_word(req_bytes[i], i == req_bytes.size() - 1);
    req_bytes.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_request();
  endtask

  // Sender holds off until every owed result is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.path_limit = v;
    @(posedge clk);
  endtask

  task automatic run_directed();
    send_text("GET /index.html HTTP/1.1");
    add_text("  pOsT /form?x=1 HTTP/1.1");
    add_crlf();
    add_text("Host: a");
    add_crlf();
    add_crlf();
    add_text("body");
    send_request();
    send_text("OpTiOnS * HTTP/1.0");
    add_text("OPTIONS *");
    add_crlf();
    add_crlf();
    send_request();
    // words that fail their length check or their match
    send_text("GET");
    send_text("POS");
    send_text("OPTIONS");
    // slash on the final byte
    send_text("GET/");
    send_text("get /");
    send_text("OPTIONS/");
    // spaces only, single extreme bytes
    send_text("   ");
    req_bytes.push_back(8'hFF);
    send_request();
    req_bytes.push_back(8'h00);
    send_request();
    send_text("PUT /x");
    // post without a usable body
    send_text("POST /x");
    add_text("POST /x");
    add_crlf();
    add_crlf();
    send_request();
    // body right after the method word, no path
    add_text("POST");
    add_crlf();
    add_crlf();
    add_text("Z");
    send_request();
    // each path terminator
    send_text("GET /a?b");
    add_text("GET /a");
    req_bytes.push_back(CH_CR);
    send_request();
    add_text("GET /a");
    req_bytes.push_back(CH_LF);
    add_text("X");
    send_request();
    // limit extremes
    write_limit('0);
    send_text("GET /a");
    write_limit(13'd1);
    send_text("GET /? q");
    write_limit(13'h1FFF);
    send_text("get /abc def");
  endtask

  // Mostly well-formed requests with random content, the rest broken or noise
  function automatic void build_random_request();
    logic [METHOD_W-1:0] v;
    int                  keep;
    v = METHOD_W'($urandom_range(1, 3));
    if ($urandom_range(99) < 75) begin
      add_spaces(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      add_verb(v);
      if ($urandom_range(7) == 0) add_text(" http:");
      add_spaces(1);
      if ($urandom_range(9) != 0) begin
        req_bytes.push_back(CH_SLASH);
        add_fill($urandom_range(0, ($urandom_range(3) == 0) ? 60 : 20));
      end
      case ($urandom_range(3))
        0: ;
        1: begin
          req_bytes.push_back(CH_QMARK);
          add_fill($urandom_range(0, 8));
        end
        2: add_text(" HTTP/1.1");
        default: add_crlf();
      endcase
      if (v == M_POST) begin
        if ($urandom_range(1) != 0) begin
          add_crlf();
          add_text("Host: h");
        end
        keep = $urandom_range(9);
        if (keep != 0) begin
          add_crlf();
          add_crlf();
          if (keep != 1) add_noise($urandom_range(1, 6));
        end
      end else if ($urandom_range(2) == 0) begin
        add_crlf();
        add_crlf();
      end
    end else begin
      case ($urandom_range(5))
        0: add_noise($urandom_range(1, 24));
        1: add_spaces($urandom_range(1, 4));
        2: begin
          // truncated method word
          add_spaces($urandom_range(0, 1));
          add_verb(v);
          keep = $urandom_range(1, req_bytes.size());
          while (req_bytes.size() > keep) void'(req_bytes.pop_back());
        end
        3: begin
          add_verb(v);
          if ($urandom_range(1) != 0) add_spaces(1);
          req_bytes.push_back(CH_SLASH);
        end
        4: begin
          add_verb(v);
          req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
          add_text(" /a b");
        end
        default: begin
          add_verb(v);
          add_noise($urandom_range(1, 20));
        end
      endcase
    end
  endfunction

  task automatic run_random_batch();
    int sent, reqs;
    sent = 0;
    reqs = 0;
    while (sent < 50 || reqs < 2) begin
      build_random_request();
      sent += req_bytes.size();
      reqs++;
      send_request();
      if ($urandom_range(11) == 0) settle();
    end
  endtask

  initial begin
    int pick;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 79 : 0;
      rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 28 : 0;
      if (phase == 0) run_directed();
      for (int sub = 0; sub < 3; sub++) begin
        pick = $urandom_range(9);
        if (pick == 0) write_limit(13'd4096);
        else if (pick == 1) write_limit(LIMIT_W'($urandom_range(1, 8191)));
        else write_limit(LIMIT_W'($urandom_range(2, 40)));
        run_random_batch();
      end
    end
    settle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
